### rtl/core/scx_pkg.sv
// Shared constants, types and the letter class function for the Soundex encoder.
package scx_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int DIGIT_SLOTS = 3;
  localparam int DIGIT_LIMIT_INT =
    (CODE_LENGTH - 1 > DIGIT_SLOTS) ? DIGIT_SLOTS : CODE_LENGTH - 1;
  localparam logic [1:0] DIGIT_LIMIT = 2'(DIGIT_LIMIT_INT);

  localparam logic [2:0] DIGIT_NONE     = 3'd0;
  localparam logic [2:0] DIGIT_NONALPHA = 3'd6;
  localparam logic [7:0] CASE_OFFSET    = 8'd32;

  typedef logic [2:0] digit_t;

  typedef struct packed {
    logic [7:0] first_char;
    digit_t     digit_one;
    digit_t     digit_two;
    digit_t     digit_three;
  } scx_code_t;

  function automatic digit_t class_digit(input logic [7:0] ch);
    logic [7:0] u;
    digit_t     d;
    u = ch;
    if (ch >= "a" && ch <= "z") begin
      u = ch - CASE_OFFSET;
    end
    unique case (u) inside
      "A", "E", "I", "O", "U", "H", "W", "Y": d = DIGIT_NONE;
      "B", "F", "P", "V":                     d = 3'd1;
      "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
      "D", "T":                               d = 3'd3;
      "M", "N":                               d = 3'd4;
      "L":                                    d = 3'd5;
      default:                                d = DIGIT_NONALPHA;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/soundex_word_encoder.sv
// Soundex word encoder top level with input handshake and result register.
//
// Takes one byte of a word per cycle; the byte flagged last_char yields one
// four-character code (first byte plus three class digits, zero padded) in the
// result register on the following cycle. Throughput is one byte per cycle:
// in_ready drops only while a finished code sits in the result register and
// out_ready is low. out_valid is registered alongside the result.
module soundex_word_encoder
  import scx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] first_char,
  output logic [2:0] digit_one,
  output logic [2:0] digit_two,
  output logic [2:0] digit_three
);

  logic      accept;
  digit_t    digit;
  scx_code_t code;
  scx_code_t result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  scx_classify u_classify (
    .char_in (char_in),
    .digit   (digit)
  );

  scx_state u_state (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last_char (last_char),
    .char_in   (char_in),
    .digit     (digit),
    .code      (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      result <= code;
    end
  end

  assign first_char  = result.first_char;
  assign digit_one   = result.digit_one;
  assign digit_two   = result.digit_two;
  assign digit_three = result.digit_three;

endmodule

### rtl/core/scx_classify.sv
// Byte to Soundex class digit decoder.
module scx_classify
  import scx_pkg::*;
(
  input  logic [7:0] char_in,
  output digit_t     digit
);

  assign digit = class_digit(char_in);

endmodule

### rtl/core/scx_state.sv
// Per-word state: first byte, kept digits and last digit, with the code it forms.
module scx_state
  import scx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       last_char,
  input  logic [7:0] char_in,
  input  digit_t     digit,
  output scx_code_t  code
);

  logic [7:0] held_first;
  digit_t     held_digits [DIGIT_SLOTS];
  logic [1:0] digits_kept;
  digit_t     previous_digit;
  logic       inside_word;

  logic [7:0] held_first_next;
  digit_t     held_digits_next [DIGIT_SLOTS];
  logic [1:0] digits_kept_next;
  digit_t     previous_digit_next;
  logic       inside_word_next;
  digit_t     out_digits [DIGIT_SLOTS];

  always_comb begin
    held_first_next     = held_first;
    held_digits_next    = held_digits;
    digits_kept_next    = digits_kept;
    previous_digit_next = previous_digit;
    inside_word_next    = inside_word;
    if (!inside_word) begin
      held_first_next  = char_in;
      inside_word_next = 1'b1;
    end else if (digit != DIGIT_NONE && digit != previous_digit) begin
      if (digits_kept < DIGIT_LIMIT) begin
        held_digits_next[digits_kept] = digit;
        digits_kept_next              = digits_kept + 2'd1;
      end
      previous_digit_next = digit;
    end
  end

  always_comb begin
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      out_digits[k] = (2'(k) < digits_kept_next) ? held_digits_next[k] : DIGIT_NONE;
    end
  end

  assign code.first_char  = held_first_next;
  assign code.digit_one   = out_digits[0];
  assign code.digit_two   = out_digits[1];
  assign code.digit_three = out_digits[2];

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      held_first     <= '0;
      held_digits    <= '{default: DIGIT_NONE};
      digits_kept    <= '0;
      previous_digit <= DIGIT_NONE;
      inside_word    <= 1'b0;
    end else if (accept) begin
      held_first     <= held_first_next;
      held_digits    <= held_digits_next;
      digits_kept    <= digits_kept_next;
      previous_digit <= previous_digit_next;
      inside_word    <= inside_word_next;
    end
  end

endmodule

### tb/soundex_word_encoder_test.sv
// Self-checking testbench for the Soundex word encoder, with scoreboard and handshake drivers.
`timescale 1ns / 1ps

module soundex_word_encoder_test;
  import scx_pkg::*;

  localparam int KEEP_MAX = (CODE_LENGTH - 1 > 3) ? 3 : CODE_LENGTH - 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD = 64;

  class soundex_scoreboard;
    logic [7:0] word_first;
    digit_t     word_digits[3];
    int         n_digits;
    digit_t     last_kept;
    bit         in_word;
    scx_code_t  codes_due[$];
    int         errors;

    function new();
      clear_word();
      errors = 0;
    endfunction

    function void clear_word();
      word_first = '0;
      word_digits = '{DIGIT_NONE, DIGIT_NONE, DIGIT_NONE};
      n_digits = 0;
      last_kept = DIGIT_NONE;
      in_word = 1'b0;
    endfunction

    function digit_t letter_class(logic [7:0] b);
      string      letter_digits;
      logic [7:0] up;
      letter_digits = "01230120022544012623010202";
      up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      if (up < "A" || up > "Z") return DIGIT_NONALPHA;
      return digit_t'(letter_digits[up - "A"] - "0");
    endfunction

    function int pending();
      return codes_due.size();
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      digit_t    d;
      scx_code_t code;
      if (!in_word) begin
        word_first = c;
        in_word = 1'b1;
      end else begin
        d = letter_class(c);
        if (d != DIGIT_NONE && d != last_kept) begin
          if (n_digits < KEEP_MAX) begin
            word_digits[n_digits] = d;
            n_digits++;
          end
          last_kept = d;
        end
      end
      if (last) begin
        code.first_char = word_first;
        code.digit_one = (n_digits > 0) ? word_digits[0] : DIGIT_NONE;
        code.digit_two = (n_digits > 1) ? word_digits[1] : DIGIT_NONE;
        code.digit_three = (n_digits > 2) ? word_digits[2] : DIGIT_NONE;
        codes_due.insert(codes_due.size(), code);
        clear_word();
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_code(scx_code_t got);
      scx_code_t want;
      if (codes_due.size() == 0) begin
        $display("%0t: code expected none actual %h %0d %0d %0d", $time,
                 got.first_char, got.digit_one, got.digit_two, got.digit_three);
        errors++;
        return;
      end
      want = codes_due.pop_front();
      compare_field("first_char", want.first_char, got.first_char);
      compare_field("digit_one", want.digit_one, got.digit_one);
      compare_field("digit_two", want.digit_two, got.digit_two);
      compare_field("digit_three", want.digit_three, got.digit_three);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_in = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] first_char;
  logic [2:0] digit_one;
  logic [2:0] digit_two;
  logic [2:0] digit_three;

  soundex_scoreboard board = new();
  int  send_idle_pct = 12;
  int  recv_idle_pct = 46;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  soundex_word_encoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_in     (char_in),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .first_char  (first_char),
    .digit_one   (digit_one),
    .digit_two   (digit_two),
    .digit_three (digit_three)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(c, last);
  endtask

  task automatic send_text(input string w, input bit end_word);
    for (int i = 0; i < w.len(); i++) begin
      send_byte(w[i], end_word && (i == w.len() - 1));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char(logic [7:0] prev);
    string quiet_letters;
    int    sel;
    quiet_letters = "AEIOUHWYaeiouhwy";
    sel = $urandom_range(99);
    if (sel < 55) return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
    if (sel < 70) return quiet_letters[$urandom_range(15)];
    if (sel < 82) return prev;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_words(input int n_bytes);
    int         sent;
    int         len;
    int         r;
    logic [7:0] c;
    sent = 0;
    c = 8'h41;
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      len = (r < 15) ? 1 : (r < 85) ? $urandom_range(2, 7) : $urandom_range(8, 14);
      for (int i = 0; i < len; i++) begin
        c = random_char(c);
        send_byte(c, i == len - 1);
      end
      sent += len;
    end
  endtask

  // receiver: random backpressure plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_code({first_char, digit_one, digit_two, digit_three});
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // one-byte words, vowel between equal classes, full code, non-letters
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("aBeBl", 1'b1);
    send_text("xcdmlz", 1'b0);
    send_byte(8'h80, 1'b1);
    send_text("h@[`{7", 1'b1);
    send_text("Ng", 1'b1);

    send_random_words(135);
    drain();
    // fill the block while the receiver holds off
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), 1'b1);
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 12;
    send_random_words(135);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_words(135);

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/scx_pkg.sv
rtl/core/scx_classify.sv
rtl/core/scx_state.sv
rtl/core/soundex_word_encoder.sv
tb/soundex_word_encoder_test.sv
